// ===== rtl/ppmdec_pkg.sv =====
// Shared types, constants and a helper function for the PPM channel decoder.
package ppmdec_pkg;

   // Defaults for the top-level parameters.
   localparam int MAX_CHANNELS_DEF = 8;
   localparam int TICKS_PER_US_DEF = 200;

   // Item kinds carried on the request side.
   localparam logic [1:0] MODE_PULSE = 2'd0;
   localparam logic [1:0] MODE_LATCH = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_SYNC_LIMIT    = 2'd0;
   localparam logic [1:0] CSR_CHANNEL_COUNT = 2'd1;
   localparam logic [1:0] CSR_RANGE_MARGIN  = 2'd2;
   localparam logic [1:0] CSR_CALIBRATING   = 2'd3;

   // Configuration reset values.
   localparam logic [15:0] SYNC_LIMIT_RST    = 16'd2500;
   localparam logic [3:0]  CHANNEL_COUNT_RST = 4'd8;
   localparam logic [7:0]  RANGE_MARGIN_RST  = 8'd50;

   // Calibration window and table reset values, in microseconds.
   localparam logic [15:0] CAL_HIGH    = 16'd2100;
   localparam logic [15:0] CAL_LOW     = 16'd900;
   localparam logic [15:0] RESET_MID   = 16'd1100;
   localparam logic [15:0] RESET_UPPER = 16'd1200;
   localparam logic [15:0] RESET_LOWER = 16'd1100;

   // Clamp limits for the offset output.
   localparam logic signed [16:0] OFS_MAX = 17'sd1100;
   localparam logic signed [16:0] OFS_MIN = -17'sd500;

   typedef struct packed {
      logic [15:0] sync_limit;
      logic [3:0]  channel_count;
      logic [7:0]  range_margin;
      logic        calibrating;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] q_hi;
      logic [15:0] q_lo;
   } stage_type;

   typedef struct packed {
      logic [2:0]         channel;
      logic               stored;
      logic [15:0]        raw_width;
      logic signed [11:0] offset_value;
      logic               in_range;
      logic               calibration_ok;
   } result_type;

   // A channel is calibrated when its limits sit inside the window and the
   // midpoint lies between them.
   function automatic logic chan_cal_ok(input logic [15:0] upper,
                                        input logic [15:0] lower,
                                        input logic [15:0] mid);
      return (upper <= CAL_HIGH) && (lower >= CAL_LOW) &&
             (mid <= upper) && (mid >= lower);
   endfunction

endpackage

// ===== rtl/ppm_channel_decoder_core.sv =====
// PPM channel decoder top level: configuration registers, pipeline control, output register.
//
// Decodes an RC PPM pulse train, one request transaction per pulse or
// command, one response transaction per request, in order. Each request
// goes through two stages: the first scales both tick counts to
// microseconds with a constant reciprocal multiplier, the second updates
// the channel pointer and tables and forms the response, which lands in
// the output register. A response passes through the stage register and
// then the output register, and a stall on the response side can hold it
// in either. A new request is taken every cycle as long as the
// response side keeps taking results; a stall there holds both stages
// and drops req_tready. Channel state is in flip-flops that reset loads
// directly, so the block is ready right after reset with no clearing
// pass. The request tuser carries the mode (pulse, latch midpoints,
// reset calibration); the response tuser says whether the pulse was
// stored to a channel. Configuration writes are always accepted and are
// meant to be made while no transaction is in flight.
module ppm_channel_decoder_core #(
   parameter int MAX_CHANNELS = ppmdec_pkg::MAX_CHANNELS_DEF,
   parameter int TICKS_PER_US = ppmdec_pkg::TICKS_PER_US_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] high_ticks, [63:32] low_ticks
   input  logic [1:0]  req_tuser,   // [1:0] mode
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] channel, [18:3] raw_width, [30:19] offset_value,
   // [31] in_range, [32] calibration_ok, [39:33] zero
   output logic [39:0] rsp_tdata,
   output logic        rsp_tuser,   // [0] stored
   // Configuration write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import ppmdec_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       stage_valid;
   stage_type  stage;
   logic       move;
   logic       accept;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   // Configuration registers; writes are never stalled.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SYNC_LIMIT:    cfg_in.sync_limit    = csr_wdata;
            CSR_CHANNEL_COUNT: cfg_in.channel_count = csr_wdata[3:0];
            CSR_RANGE_MARGIN:  cfg_in.range_margin  = csr_wdata[7:0];
            CSR_CALIBRATING:   cfg_in.calibrating   = csr_wdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_limit    <= SYNC_LIMIT_RST;
         cfg_ff.channel_count <= CHANNEL_COUNT_RST;
         cfg_ff.range_margin  <= RANGE_MARGIN_RST;
         cfg_ff.calibrating   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The decode stage moves into the output register whenever the output
   // register is empty or is being emptied in the same cycle.
   assign move       = stage_valid && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !stage_valid || move;
   assign accept     = req_tvalid && req_tready;

   ppmdec_scale #(
      .TICKS_PER_US(TICKS_PER_US)
   ) u_scale (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .drain      (move),
      .mode       (req_tuser),
      .high_ticks (req_tdata[31:0]),
      .low_ticks  (req_tdata[63:32]),
      .valid      (stage_valid),
      .stage      (stage)
   );

   ppmdec_chan #(
      .MAX_CHANNELS(MAX_CHANNELS)
   ) u_chan (
      .clock  (clock),
      .reset  (reset),
      .update (move),
      .stage  (stage),
      .cfg    (cfg_ff),
      .result (result)
   );

   // Output register: holds a finished response until it is taken.
   always_comb begin
      if (move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.stored;
   assign rsp_tdata  = {7'd0, rsp_ff.calibration_ok, rsp_ff.in_range,
                        rsp_ff.offset_value, rsp_ff.raw_width, rsp_ff.channel};

endmodule

// ===== rtl/ppmdec_scale.sv =====
// Tick-to-microsecond scaling stage: reciprocal multiply and stage register.
module ppmdec_scale #(
   parameter int TICKS_PER_US = ppmdec_pkg::TICKS_PER_US_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic                  drain,
   input  logic [1:0]            mode,
   input  logic [31:0]           high_ticks,
   input  logic [31:0]           low_ticks,
   output logic                  valid,
   output ppmdec_pkg::stage_type stage
);
   import ppmdec_pkg::*;

   // Exact division by a constant: q = (x * RECIP) >> (32 + SHIFT), with
   // RECIP rounded up so that every 32-bit dividend divides exactly.
   localparam int SHIFT = $clog2(TICKS_PER_US);
   localparam logic [63:0] RECIP_WIDE =
      ((64'd1 << (32 + SHIFT)) + 64'(TICKS_PER_US) - 64'd1) / 64'(TICKS_PER_US);
   localparam logic [32:0] RECIP = RECIP_WIDE[32:0];

   logic [64:0] prod_hi;
   logic [64:0] prod_lo;
   logic        valid_ff;
   logic        valid_in;
   stage_type   stage_ff;
   stage_type   stage_in;

   assign prod_hi = 65'(high_ticks) * 65'(RECIP);
   assign prod_lo = 65'(low_ticks) * 65'(RECIP);

   always_comb begin
      stage_in.mode = mode;
      stage_in.q_hi = prod_hi[32 + SHIFT +: 16];
      stage_in.q_lo = prod_lo[32 + SHIFT +: 16];
      if (load) begin
         valid_in = 1'b1;
      end else if (drain) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         stage_ff <= stage_in;
      end
   end

   assign valid = valid_ff;
   assign stage = stage_ff;

endmodule

// ===== rtl/ppmdec_chan.sv =====
// Channel state (pointer, raw widths, calibration tables) and result decode.
module ppmdec_chan #(
   parameter int MAX_CHANNELS = ppmdec_pkg::MAX_CHANNELS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   update,
   input  ppmdec_pkg::stage_type  stage,
   input  ppmdec_pkg::cfg_type    cfg,
   output ppmdec_pkg::result_type result
);
   import ppmdec_pkg::*;

   localparam int PTR_W = $clog2(MAX_CHANNELS + 1);
   localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

   logic [PTR_W-1:0] ptr_ff;
   logic [PTR_W-1:0] ptr_in;
   logic [15:0]      raw_ff   [MAX_CHANNELS];
   logic [15:0]      raw_in   [MAX_CHANNELS];
   logic [15:0]      mid_ff   [MAX_CHANNELS];
   logic [15:0]      mid_in   [MAX_CHANNELS];
   logic [15:0]      upper_ff [MAX_CHANNELS];
   logic [15:0]      upper_in [MAX_CHANNELS];
   logic [15:0]      lower_ff [MAX_CHANNELS];
   logic [15:0]      lower_in [MAX_CHANNELS];
   logic [MAX_CHANNELS-1:0] ok_next;

   logic [PTR_W-1:0]  active;
   logic [15:0]       width;
   logic              is_pulse;
   logic              store;
   logic [IDX_W-1:0]  sel;
   logic [15:0]       cur_mid;
   logic [15:0]       new_up;
   logic [15:0]       new_lo;
   logic signed [16:0] diff;
   logic signed [16:0] diff_clamped;
   logic [16:0]       up_wide;
   logic [16:0]       w_plus;
   logic              all_ok;

   always_comb begin
      if (5'(cfg.channel_count) > 5'(MAX_CHANNELS)) begin
         active = PTR_W'(MAX_CHANNELS);
      end else begin
         active = PTR_W'(cfg.channel_count);
      end
      width    = stage.q_hi + stage.q_lo;
      is_pulse = (stage.mode == MODE_PULSE);
      store    = is_pulse && (width <= cfg.sync_limit) && (ptr_ff < active);
      sel      = store ? ptr_ff[IDX_W-1:0] : '0;
      cur_mid  = mid_ff[sel];

      // Limits widen only toward new extremes strictly inside the window.
      new_up = upper_ff[sel];
      new_lo = lower_ff[sel];
      if (cfg.calibrating && (width > upper_ff[sel]) && (width < CAL_HIGH)) begin
         new_up = width;
      end
      if (cfg.calibrating && (width < lower_ff[sel]) && (width > CAL_LOW)) begin
         new_lo = width;
      end

      for (int i = 0; i < MAX_CHANNELS; i++) begin
         raw_in[i]   = raw_ff[i];
         mid_in[i]   = mid_ff[i];
         upper_in[i] = upper_ff[i];
         lower_in[i] = lower_ff[i];
         if (store && (sel == IDX_W'(i))) begin
            raw_in[i]   = width;
            upper_in[i] = new_up;
            lower_in[i] = new_lo;
         end
         if ((stage.mode == MODE_LATCH) && (PTR_W'(i) < active)) begin
            mid_in[i] = raw_ff[i];
         end
         if ((stage.mode == MODE_CLEAR) && (PTR_W'(i) < active)) begin
            mid_in[i]   = RESET_MID;
            upper_in[i] = RESET_UPPER;
            lower_in[i] = RESET_LOWER;
         end
         ok_next[i] = chan_cal_ok(upper_in[i], lower_in[i], mid_in[i]);
      end

      all_ok = 1'b1;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
         if ((PTR_W'(i) < active) && !ok_next[i]) begin
            all_ok = 1'b0;
         end
      end

      if (store) begin
         ptr_in = ptr_ff + PTR_W'(1);
      end else if (is_pulse) begin
         ptr_in = '0;
      end else begin
         ptr_in = ptr_ff;
      end

      diff = $signed({1'b0, width}) - $signed({1'b0, cur_mid});
      if (diff > OFS_MAX) begin
         diff_clamped = OFS_MAX;
      end else if (diff < OFS_MIN) begin
         diff_clamped = OFS_MIN;
      end else begin
         diff_clamped = diff;
      end
      up_wide = {1'b0, new_up} + 17'(cfg.range_margin);
      w_plus  = {1'b0, width} + 17'(cfg.range_margin);

      result.channel        = store ? 3'(ptr_ff) : 3'd0;
      result.stored         = store;
      result.raw_width      = is_pulse ? width : 16'd0;
      result.offset_value   = store ? 12'(diff_clamped) : 12'sd0;
      result.in_range       = store && ({1'b0, width} <= up_wide) &&
                              (w_plus >= {1'b0, new_lo});
      result.calibration_ok = store ? ok_next[sel] : all_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            raw_ff[i]   <= 16'd0;
            mid_ff[i]   <= RESET_MID;
            upper_ff[i] <= RESET_UPPER;
            lower_ff[i] <= RESET_LOWER;
         end
      end else if (update) begin
         ptr_ff <= ptr_in;
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            raw_ff[i]   <= raw_in[i];
            mid_ff[i]   <= mid_in[i];
            upper_ff[i] <= upper_in[i];
            lower_ff[i] <= lower_in[i];
         end
      end
   end

endmodule

// ===== rtl/ppmdec_checker.sv =====
// Port-level checker for the PPM channel decoder and its bind statement.
module ppmdec_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tuser
);

   // A stalled response keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // A new response always comes from a taken request.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("response without a matching request");

   // Unstored responses (sync pulses, surplus pulses and commands) report no channel, offset or range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> (rsp_tdata[2:0] == 3'd0) &&
                                   (rsp_tdata[30:19] == 12'd0) && !rsp_tdata[31])
      else $error("unstored response carries channel data");

   // The offset always lies within its clamp range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[30:19]) >= -12'sd500) &&
                     ($signed(rsp_tdata[30:19]) <= 12'sd1100))
      else $error("offset outside clamp range");

endmodule

bind ppm_channel_decoder_core ppmdec_checker u_ppmdec_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
